// ----- src/rau_pkg.sv -----
// shared types and codes for the rational arithmetic unit
package rau_pkg;

    localparam int WORD_BITS_DEF = 64;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_GCD = 2'd2
    } rau_op_t;

    typedef struct packed {
        logic    start;
        rau_op_t op;
    } rau_cmd_t;

endpackage

// ----- src/rational_arithmetic_unit.sv -----
// rational arithmetic unit top level: operand reduction, compare, add/sub/mul/div sequencer
// all work runs one request at a time on the one shared iterative unit (multiply, divide and gcd)
// throughput: one item at a time; s_tready is high only while the block is idle
// reset: aresetn synchronous active low clears the sequencer and the output valid
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // a_num, a_den, b_num, b_den
    input  logic [2:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // res_num, res_den
    output logic [3:0]   m_tuser    // is_less, is_equal, status
);
    import rau_pkg::*;

    localparam int W = WORD_BITS;

    typedef enum logic [31:0] {
        S_IDLE  = 32'h00000001,
        S_A_GCD = 32'h00000002,
        S_A_DVN = 32'h00000004,
        S_A_DVD = 32'h00000008,
        S_B_GCD = 32'h00000010,
        S_B_DVN = 32'h00000020,
        S_B_DVD = 32'h00000040,
        S_CHECK = 32'h00000080,
        S_CMP1  = 32'h00000100,
        S_CMP2  = 32'h00000200,
        S_DISP  = 32'h00000400,
        S_MG1   = 32'h00000800,
        S_MD1   = 32'h00001000,
        S_MD2   = 32'h00002000,
        S_MG2   = 32'h00004000,
        S_MD3   = 32'h00008000,
        S_MD4   = 32'h00010000,
        S_MM1   = 32'h00020000,
        S_MM2   = 32'h00040000,
        S_AG    = 32'h00080000,
        S_AD1   = 32'h00100000,
        S_AD2   = 32'h00200000,
        S_AM1   = 32'h00400000,
        S_AM2   = 32'h00800000,
        S_ASUM  = 32'h01000000,
        S_AR    = 32'h02000000,
        S_AG2   = 32'h04000000,
        S_AQ    = 32'h08000000,
        S_AB    = 32'h10000000,
        S_AMD   = 32'h20000000,
        S_EMIT  = 32'h40000000,
        S_OUT   = 32'h80000000
    } state_t;

    state_t          state_reg, state_next;
    logic            issued_reg, issued_next;
    logic [2:0]      act_reg, act_next;
    logic            an_reg, an_next, bn_reg, bn_next;
    logic [W-1:0]    am_reg, am_next, ad_reg, ad_next;
    logic [W-1:0]    bm_reg, bm_next, bd_reg, bd_next;
    logic [W-1:0]    g_reg, g_next, e_reg, e_next;
    logic [2*W-1:0]  p1_reg, p1_next, p2_reg, p2_next, t_reg, t_next;
    logic            tneg_reg, tneg_next;
    logic            less_reg, less_next, eq_reg, eq_next;
    logic [63:0]     res_num_reg, res_num_next, res_den_reg, res_den_next;
    logic [1:0]      status_reg, status_next;

    rau_cmd_t        cmd;
    rau_op_t         op_sel;
    logic            call;
    logic [2*W-1:0]  opa;
    logic [W-1:0]    opb;
    logic            iter_done;
    logic [2*W-1:0]  iter_acc;
    logic [W-1:0]    iter_rem;

    logic [W-1:0]    rna, rnb;
    logic            sn1, sn2, less_c, eq_c;
    logic [W-1:0]    half, lim, nv;
    logic signed [W-1:0] nv_s;
    logic signed [63:0]  nv_ext;
    logic            ovf;

    rau_iter #(.WORD_BITS(W)) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (opa),
        .opb     (opb),
        .done    (iter_done),
        .acc     (iter_acc),
        .rem     (iter_rem)
    );

    assign rna  = s_tdata[W-1:0];
    assign rnb  = s_tdata[128+W-1:128];
    assign sn1  = an_reg & (|p1_reg);
    assign sn2  = bn_reg & (|p2_reg);
    assign less_c = (sn1 & ~sn2) | ((sn1 == sn2) & (sn1 ? (p2_reg < p1_reg) : (p1_reg < p2_reg)));
    assign eq_c   = (sn1 == sn2) & (p1_reg == p2_reg);
    assign half = {1'b1, {(W-1){1'b0}}};
    assign lim  = tneg_reg ? half : half - 1'b1;
    assign ovf  = (|t_reg[2*W-1:W]) || (t_reg[W-1:0] > lim) || (|p2_reg[2*W-1:W]);
    assign nv   = tneg_reg ? -t_reg[W-1:0] : t_reg[W-1:0];
    assign nv_s = nv;
    assign nv_ext = 64'(nv_s);

    assign cmd       = '{start: call & ~issued_reg, op: op_sel};
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {res_den_reg, res_num_reg};
    assign m_tuser   = {status_reg, eq_reg, less_reg};

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        an_next      = an_reg;
        bn_next      = bn_reg;
        am_next      = am_reg;
        ad_next      = ad_reg;
        bm_next      = bm_reg;
        bd_next      = bd_reg;
        g_next       = g_reg;
        e_next       = e_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        t_next       = t_reg;
        tneg_next    = tneg_reg;
        less_next    = less_reg;
        eq_next      = eq_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        status_next  = status_reg;
        call         = 1'b0;
        op_sel       = OP_MUL;
        opa          = '0;
        opb          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    an_next    = rna[W-1];
                    am_next    = rna[W-1] ? -rna : rna;
                    ad_next    = s_tdata[64+W-1:64];
                    bn_next    = rnb[W-1];
                    bm_next    = rnb[W-1] ? -rnb : rnb;
                    bd_next    = s_tdata[192+W-1:192];
                    state_next = S_A_GCD;
                end
            end
            S_A_GCD: begin
                if (ad_reg == '0) begin
                    state_next = S_B_GCD;
                end else begin
                    call = 1'b1; op_sel = OP_GCD; opa = (2*W)'(am_reg); opb = ad_reg;
                    if (iter_done) begin g_next = iter_rem; state_next = S_A_DVN; end
                end
            end
            S_A_DVN: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(am_reg); opb = g_reg;
                if (iter_done) begin am_next = iter_acc[W-1:0]; state_next = S_A_DVD; end
            end
            S_A_DVD: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(ad_reg); opb = g_reg;
                if (iter_done) begin ad_next = iter_acc[W-1:0]; state_next = S_B_GCD; end
            end
            S_B_GCD: begin
                if (bd_reg == '0) begin
                    state_next = S_CHECK;
                end else begin
                    call = 1'b1; op_sel = OP_GCD; opa = (2*W)'(bm_reg); opb = bd_reg;
                    if (iter_done) begin g_next = iter_rem; state_next = S_B_DVN; end
                end
            end
            S_B_DVN: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(bm_reg); opb = g_reg;
                if (iter_done) begin bm_next = iter_acc[W-1:0]; state_next = S_B_DVD; end
            end
            S_B_DVD: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(bd_reg); opb = g_reg;
                if (iter_done) begin bd_next = iter_acc[W-1:0]; state_next = S_CHECK; end
            end
            S_CHECK: begin
                if (ad_reg == '0 || bd_reg == '0) begin
                    res_num_next = '0;
                    res_den_next = '0;
                    less_next    = 1'b0;
                    eq_next      = 1'b0;
                    status_next  = ST_DIVZ;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_CMP1;
                end
            end
            S_CMP1: begin
                call = 1'b1; op_sel = OP_MUL; opa = (2*W)'(am_reg); opb = bd_reg;
                if (iter_done) begin p1_next = iter_acc; state_next = S_CMP2; end
            end
            S_CMP2: begin
                call = 1'b1; op_sel = OP_MUL; opa = (2*W)'(bm_reg); opb = ad_reg;
                if (iter_done) begin p2_next = iter_acc; state_next = S_DISP; end
            end
            S_DISP: begin
                less_next = less_c;
                eq_next   = eq_c;
                case (act_reg)
                    ACT_ADD: state_next = S_AG;
                    ACT_SUB: begin
                        bn_next    = (bm_reg != '0) && !bn_reg;
                        state_next = S_AG;
                    end
                    ACT_MUL: state_next = S_MG1;
                    ACT_DIV: begin
                        if (bm_reg == '0) begin
                            res_num_next = '0;
                            res_den_next = '0;
                            status_next  = ST_DIVZ;
                            state_next   = S_OUT;
                        end else begin
                            bm_next    = bd_reg;
                            bd_next    = bm_reg;
                            state_next = S_MG1;
                        end
                    end
                    default: begin
                        res_num_next = '0;
                        res_den_next = 64'd1;
                        status_next  = ST_OK;
                        state_next   = S_OUT;
                    end
                endcase
            end
            S_MG1: begin
                call = 1'b1; op_sel = OP_GCD; opa = (2*W)'(am_reg); opb = bd_reg;
                if (iter_done) begin g_next = iter_rem; state_next = S_MD1; end
            end
            S_MD1: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(am_reg); opb = g_reg;
                if (iter_done) begin am_next = iter_acc[W-1:0]; state_next = S_MD2; end
            end
            S_MD2: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(bd_reg); opb = g_reg;
                if (iter_done) begin bd_next = iter_acc[W-1:0]; state_next = S_MG2; end
            end
            S_MG2: begin
                call = 1'b1; op_sel = OP_GCD; opa = (2*W)'(bm_reg); opb = ad_reg;
                if (iter_done) begin g_next = iter_rem; state_next = S_MD3; end
            end
            S_MD3: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(bm_reg); opb = g_reg;
                if (iter_done) begin bm_next = iter_acc[W-1:0]; state_next = S_MD4; end
            end
            S_MD4: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(ad_reg); opb = g_reg;
                if (iter_done) begin ad_next = iter_acc[W-1:0]; state_next = S_MM1; end
            end
            S_MM1: begin
                call = 1'b1; op_sel = OP_MUL; opa = (2*W)'(am_reg); opb = bm_reg;
                if (iter_done) begin
                    t_next     = iter_acc;
                    tneg_next  = an_reg ^ bn_reg;
                    state_next = S_MM2;
                end
            end
            S_MM2: begin
                call = 1'b1; op_sel = OP_MUL; opa = (2*W)'(ad_reg); opb = bd_reg;
                if (iter_done) begin p2_next = iter_acc; state_next = S_EMIT; end
            end
            S_AG: begin
                call = 1'b1; op_sel = OP_GCD; opa = (2*W)'(ad_reg); opb = bd_reg;
                if (iter_done) begin g_next = iter_rem; state_next = S_AD1; end
            end
            S_AD1: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(ad_reg); opb = g_reg;
                if (iter_done) begin ad_next = iter_acc[W-1:0]; state_next = S_AD2; end
            end
            S_AD2: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(bd_reg); opb = g_reg;
                if (iter_done) begin e_next = iter_acc[W-1:0]; state_next = S_AM1; end
            end
            S_AM1: begin
                call = 1'b1; op_sel = OP_MUL; opa = (2*W)'(am_reg); opb = e_reg;
                if (iter_done) begin p1_next = iter_acc; state_next = S_AM2; end
            end
            S_AM2: begin
                call = 1'b1; op_sel = OP_MUL; opa = (2*W)'(bm_reg); opb = ad_reg;
                if (iter_done) begin p2_next = iter_acc; state_next = S_ASUM; end
            end
            S_ASUM: begin
                if (an_reg == bn_reg) begin
                    t_next    = p1_reg + p2_reg;
                    tneg_next = an_reg;
                end else if (p1_reg >= p2_reg) begin
                    t_next    = p1_reg - p2_reg;
                    tneg_next = an_reg;
                end else begin
                    t_next    = p2_reg - p1_reg;
                    tneg_next = bn_reg;
                end
                if (an_reg != bn_reg && p1_reg == p2_reg) begin
                    res_num_next = '0;
                    res_den_next = 64'd1;
                    status_next  = ST_OK;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_AR;
                end
            end
            S_AR: begin
                call = 1'b1; op_sel = OP_DIV; opa = t_reg; opb = g_reg;
                if (iter_done) begin e_next = iter_rem; state_next = S_AG2; end
            end
            S_AG2: begin
                call = 1'b1; op_sel = OP_GCD; opa = (2*W)'(e_reg); opb = g_reg;
                if (iter_done) begin g_next = iter_rem; state_next = S_AQ; end
            end
            S_AQ: begin
                call = 1'b1; op_sel = OP_DIV; opa = t_reg; opb = g_reg;
                if (iter_done) begin t_next = iter_acc; state_next = S_AB; end
            end
            S_AB: begin
                call = 1'b1; op_sel = OP_DIV; opa = (2*W)'(bd_reg); opb = g_reg;
                if (iter_done) begin e_next = iter_acc[W-1:0]; state_next = S_AMD; end
            end
            S_AMD: begin
                call = 1'b1; op_sel = OP_MUL; opa = (2*W)'(ad_reg); opb = e_reg;
                if (iter_done) begin p2_next = iter_acc; state_next = S_EMIT; end
            end
            S_EMIT: begin
                if (t_reg == '0) begin
                    res_num_next = '0;
                    res_den_next = 64'd1;
                    status_next  = ST_OK;
                end else if (ovf) begin
                    res_num_next = '0;
                    res_den_next = '0;
                    status_next  = ST_OVF;
                end else begin
                    res_num_next = nv_ext;
                    res_den_next = 64'(p2_reg[W-1:0]);
                    status_next  = ST_OK;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (iter_done)                 issued_next = 1'b0;
        else if (call && !issued_reg)  issued_next = 1'b1;
        else                           issued_next = issued_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
        act_reg     <= act_next;
        an_reg      <= an_next;
        bn_reg      <= bn_next;
        am_reg      <= am_next;
        ad_reg      <= ad_next;
        bm_reg      <= bm_next;
        bd_reg      <= bd_next;
        g_reg       <= g_next;
        e_reg       <= e_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        t_reg       <= t_next;
        tneg_reg    <= tneg_next;
        less_reg    <= less_next;
        eq_reg      <= eq_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        status_reg  <= status_next;
    end

`ifndef SYNTHESIS
    a_zero_den_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && status_reg == ST_OK && res_num_reg == '0)
        |-> res_den_reg == 64'd1)
        else $error("zero result without unit denominator");
    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_done |-> issued_reg)
        else $error("shared unit finished without a request");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |->
        (status_reg == ST_OK || status_reg == ST_DIVZ || status_reg == ST_OVF))
        else $error("bad status code");
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> !(less_reg && eq_reg))
        else $error("less and equal both set");
`endif

endmodule

// ----- src/rau_iter.sv -----
// shared iterative unit: shift-add multiply, shift-subtract divide, binary gcd
module rau_iter #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rau_pkg::rau_cmd_t        cmd,
    input  logic [2*WORD_BITS-1:0]   opa,
    input  logic [WORD_BITS-1:0]     opb,
    output logic                     done,
    output logic [2*WORD_BITS-1:0]   acc,
    output logic [WORD_BITS-1:0]     rem
);
    import rau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(2 * W + 1);
    localparam int KW = $clog2(W);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    rau_op_t         op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [2*W-1:0]  acc_reg, acc_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    aux_reg, aux_next;
    logic [KW-1:0]   k_reg, k_next;

    logic [W:0]      msum;
    logic [W:0]      dtrial;
    logic [W:0]      dsub;
    logic            dge;

    assign msum   = {1'b0, acc_reg[2*W-1:W]} + (acc_reg[0] ? {1'b0, aux_reg} : {(W+1){1'b0}});
    assign dtrial = {rem_reg, acc_reg[2*W-1]};
    assign dge    = dtrial >= {1'b0, aux_reg};
    assign dsub   = dtrial - {1'b0, aux_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        aux_next  = aux_reg;
        k_next    = k_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            aux_next  = opb;
            k_next    = '0;
            unique case (cmd.op)
                OP_MUL: begin
                    acc_next = {{W{1'b0}}, opa[W-1:0]};
                    cnt_next = CW'(W);
                end
                OP_DIV: begin
                    acc_next = opa;
                    rem_next = '0;
                    cnt_next = CW'(2 * W);
                end
                OP_GCD: begin
                    rem_next = opa[W-1:0];
                end
                default: busy_next = 1'b0;
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_MUL: begin
                    acc_next = {msum, acc_reg[W-1:1]};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OP_DIV: begin
                    acc_next = {acc_reg[2*W-2:0], dge};
                    rem_next = dge ? dsub[W-1:0] : dtrial[W-1:0];
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OP_GCD: begin
                    if (rem_reg == '0) begin
                        rem_next  = aux_reg << k_reg;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else if (aux_reg == '0) begin
                        rem_next  = rem_reg << k_reg;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else if (!rem_reg[0] && !aux_reg[0]) begin
                        rem_next = rem_reg >> 1;
                        aux_next = aux_reg >> 1;
                        k_next   = k_reg + 1'b1;
                    end else if (!rem_reg[0]) begin
                        rem_next = rem_reg >> 1;
                    end else if (!aux_reg[0]) begin
                        aux_next = aux_reg >> 1;
                    end else if (rem_reg >= aux_reg) begin
                        rem_next = rem_reg - aux_reg;
                    end else begin
                        aux_next = aux_reg - rem_reg;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        aux_reg <= aux_next;
        k_reg   <= k_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign rem  = rem_reg;

endmodule

// ----- tb/rational_arithmetic_unit_test.sv -----
// rational arithmetic unit testbench: directed and random items, checked against the table or predictor
module rational_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int WB = WORD_BITS_DEF;
    localparam logic [2:0] ACT_CMP = 3'd4;
    localparam logic [63:0] MASK = {64{1'b1}} >> (64 - WB);

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] a_num, a_den, b_num, b_den;
    } op_item_t;

    typedef struct packed {
        logic [63:0] res_num, res_den;
        logic        is_less, is_equal;
        logic [1:0]  status;
    } quotient_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [3:0]   m_tuser;

    quotient_t pending_results[$];
    int        errors;
    bit        quiet_phase;

    rational_arithmetic_unit #(.WORD_BITS(WB)) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [63:0] gcd_w(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // fits the signed/unsigned word; returns status
    function automatic logic [1:0] pack_frac(logic neg, logic [127:0] n, logic [127:0] d,
                                             ref quotient_t r);
        logic [127:0] lim;
        lim = neg ? {64'd0, (MASK >> 1) + 64'd1} : {64'd0, MASK >> 1};
        if (n == 0) begin
            r.res_num = 0;
            r.res_den = 1;
            return ST_OK;
        end
        if (n > lim || d > {64'd0, MASK}) begin
            r.res_num = 0;
            r.res_den = 0;
            return ST_OVF;
        end
        r.res_num = neg ? -n[63:0] : n[63:0];
        r.res_den = d[63:0];
        return ST_OK;
    endfunction

    function automatic void read_frac(logic [63:0] rn, logic [63:0] rd, output logic neg,
                                      output logic [63:0] mag, output logic [63:0] den);
        logic [63:0] g;
        rn &= MASK;
        den = rd & MASK;
        neg = rn[WB-1];
        mag = neg ? (~rn + 64'd1) & MASK : rn;
        if (den == 0) return;
        g = gcd_w(mag, den);
        mag /= g;
        den /= g;
        if (mag == 0) begin
            den = 1;
            neg = 1'b0;
        end
    endfunction

    function automatic quotient_t predict_quotient(op_item_t it);
        quotient_t r;
        logic an, bn, rneg;
        logic [63:0] am, ad, bm, bd, g, g1, g2, xm, xd;
        logic signed [129:0] lhs, rhs, sum;
        logic [127:0] mag, q;
        read_frac(it.a_num, it.a_den, an, am, ad);
        read_frac(it.b_num, it.b_den, bn, bm, bd);
        r = '0;
        if (ad == 0 || bd == 0) begin
            r.status = ST_DIVZ;
            return r;
        end
        lhs = $signed({2'b00, 128'(am) * 128'(bd)});
        rhs = $signed({2'b00, 128'(bm) * 128'(ad)});
        if (an) lhs = -lhs;
        if (bn) rhs = -rhs;
        r.is_less = lhs < rhs;
        r.is_equal = lhs == rhs;
        case (it.action) inside
            ACT_ADD, ACT_SUB: begin
                g = gcd_w(ad, bd);
                lhs = $signed({2'b00, 128'(am) * 128'(bd / g)});
                rhs = $signed({2'b00, 128'(bm) * 128'(ad / g)});
                if (an) lhs = -lhs;
                if (bn ^ (it.action == ACT_SUB)) rhs = -rhs;
                sum = lhs + rhs;
                rneg = sum < 0;
                mag = rneg ? 128'(-sum) : 128'(sum);
                if (mag == 0) begin
                    r.status = pack_frac(1'b0, 0, 1, r);
                end else begin
                    g2 = gcd_w(64'(mag % 128'(g)), g);
                    q = mag / 128'(g2);
                    r.status = pack_frac(rneg, q, 128'(ad / g) * 128'(bd / g2), r);
                end
            end
            ACT_MUL, ACT_DIV: begin
                if (it.action == ACT_DIV && bm == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    xm = bm;
                    xd = bd;
                    if (it.action == ACT_DIV) begin
                        xm = bd;
                        xd = bm;
                    end
                    g1 = gcd_w(am, xd);
                    g2 = gcd_w(xm, ad);
                    r.status = pack_frac(an != bn, 128'(am / g1) * 128'(xm / g2),
                                         128'(ad / g2) * 128'(xd / g1), r);
                end
            end
            default: r.res_den = 1;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_val();
        case ($urandom_range(0, 6))
            0: return rand64();
            1: return 64'($urandom_range(0, 20));
            2: return -64'($urandom_range(0, 20));
            3: return 64'($urandom);
            4: return {1'b0, 63'(rand64() >> $urandom_range(0, 62))};
            5: return 64'($urandom_range(0, 3)) << $urandom_range(0, 63);
            default: return 64'(signed'($urandom_range(0, 1000)) - 500);
        endcase
    endfunction

    task automatic send_item(op_item_t it, quotient_t want, bit use_want);
        pending_results.push_back(use_want ? want : predict_quotient(it));
        while (!quiet_phase && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.b_den, it.b_num, it.a_den, it.a_num};
        s_tuser  <= it.action;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        quotient_t want, got;
        if (aresetn) begin
            m_tready <= quiet_phase || ($urandom_range(0, 99) >= 23);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[63:0], m_tdata[127:64], m_tuser[0], m_tuser[1], m_tuser[3:2]};
                if (pending_results.size() == 0) begin
                    $display("unexpected result item");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.res_num !== want.res_num)
                        report_mismatch("res_num", got.res_num, want.res_num);
                    if (got.res_den !== want.res_den)
                        report_mismatch("res_den", got.res_den, want.res_den);
                    if (got.is_less !== want.is_less)
                        report_mismatch("is_less", 64'(got.is_less), 64'(want.is_less));
                    if (got.is_equal !== want.is_equal)
                        report_mismatch("is_equal", 64'(got.is_equal), 64'(want.is_equal));
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                end
            end
        end
    end

    localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL1 = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        op_item_t  it;
        bit        typed;
        quotient_t want;
    } stim_row_t;

    stim_row_t directed_rows[] = '{
        '{'{ACT_ADD, 64'd1, 64'd2, 64'd1, 64'd3}, 1, '{64'd5, 64'd6, 1'b0, 1'b0, ST_OK}},
        '{'{ACT_SUB, 64'd1, 64'd2, 64'd1, 64'd2}, 1, '{64'd0, 64'd1, 1'b0, 1'b1, ST_OK}},
        '{'{ACT_MUL, 64'd2, 64'd3, 64'd3, 64'd4}, 1, '{64'd1, 64'd2, 1'b1, 1'b0, ST_OK}},
        '{'{ACT_DIV, 64'd1, 64'd2, 64'd0, 64'd5}, 1, '{64'd0, 64'd0, 1'b0, 1'b0, ST_DIVZ}},
        '{'{ACT_ADD, 64'd1, 64'd0, 64'd1, 64'd3}, 1, '{64'd0, 64'd0, 1'b0, 1'b0, ST_DIVZ}},
        '{'{ACT_CMP, 64'd3, 64'd1, 64'd3, 64'd0}, 1, '{64'd0, 64'd0, 1'b0, 1'b0, ST_DIVZ}},
        '{'{ACT_CMP, -64'd1, 64'd3, 64'd1, 64'd3}, 1, '{64'd0, 64'd1, 1'b1, 1'b0, ST_OK}},
        '{'{3'd7, 64'd2, 64'd4, 64'd1, 64'd2}, 1, '{64'd0, 64'd1, 1'b0, 1'b1, ST_OK}},
        '{'{3'd5, 64'd5, 64'd1, 64'd4, 64'd1}, 0, '0},
        '{'{3'd6, MINN, 64'd1, MAXP, ALL1}, 0, '0},
        '{'{ACT_ADD, MAXP, 64'd1, MAXP, 64'd1}, 1, '{64'd0, 64'd0, 1'b0, 1'b1, ST_OVF}},
        '{'{ACT_MUL, MINN, 64'd1, -64'd1, 64'd1}, 1, '{64'd0, 64'd0, 1'b1, 1'b0, ST_OVF}},
        '{'{ACT_MUL, MINN, 64'd1, 64'd1, 64'd1}, 1, '{MINN, 64'd1, 1'b1, 1'b0, ST_OK}},
        '{'{ACT_SUB, MINN, 64'd1, 64'd1, 64'd1}, 0, '0},
        '{'{ACT_ADD, MAXP, ALL1, MINN, ALL1}, 0, '0},
        '{'{ACT_DIV, 64'd1, ALL1, 64'd1, 64'd2}, 0, '0},
        '{'{ACT_MUL, 64'd6, 64'd4, 64'd10, 64'd15}, 0, '0},
        '{'{ACT_ADD, 64'd0, 64'd7, 64'd0, 64'd9}, 1, '{64'd0, 64'd1, 1'b0, 1'b1, ST_OK}},
        '{'{ACT_DIV, -64'd3, 64'd4, -64'd9, 64'd8}, 0, '0},
        '{'{ACT_SUB, ALL1, ALL1, 64'd1, ALL1 - 64'd1}, 0, '0},
        '{'{ACT_ADD, 64'd1, 64'd6, 64'd1, 64'd10}, 0, '0},
        '{'{ACT_DIV, MAXP, 64'd1, MINN, 64'd1}, 0, '0}
    };

    initial begin
        op_item_t it;
        errors = 0;
        quiet_phase = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].want, directed_rows[i].typed);
        for (int n = 0; n < 900; n++) begin
            quiet_phase = (n >= 300 && n < 420);
            if (n == 600) begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            it.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7))
                                                     : 3'($urandom_range(0, 3));
            it.a_num = pick_val();
            it.b_num = pick_val();
            it.a_den = pick_val();
            it.b_den = pick_val();
            if ($urandom_range(0, 39) != 0 && it.a_den == 0) it.a_den = 1;
            if ($urandom_range(0, 39) != 0 && it.b_den == 0) it.b_den = 1;
            send_item(it, '0, 0);
        end
        quiet_phase = 1'b0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/rau_pkg.sv
src/rau_iter.sv
src/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
